// ----- rtl/kalman_velocity_fusion_2axis_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the two-axis velocity fusion core
// Clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef KALMAN_VELOCITY_FUSION_2AXIS_CORE_DEFINES_SVH
`define KALMAN_VELOCITY_FUSION_2AXIS_CORE_DEFINES_SVH

// same-cycle implication
`define KVF2_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KVF2_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kvf2_pkg.sv -----
// ---------------------------------------------------------------------------
// kvf2_pkg
// Shared constants and register map of the two-axis velocity fusion core.
// ---------------------------------------------------------------------------
package kvf2_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int TS_BITS         = 16;

  localparam logic [63:0] PROCESS_NOISE_RST    = 64'd655;
  localparam logic [63:0] MEAS_NOISE_RST       = 64'd65536;
  localparam logic [63:0] INITIAL_VARIANCE_RST = 64'd65536;
  localparam logic [63:0] INITIAL_VX_RST       = 64'd0;
  localparam logic [63:0] INITIAL_VY_RST       = 64'd0;

  typedef enum logic [2:0] {
    REG_PROCESS_NOISE    = 3'd0,
    REG_MEAS_NOISE       = 3'd1,
    REG_INITIAL_VARIANCE = 3'd2,
    REG_INITIAL_VX       = 3'd3,
    REG_INITIAL_VY       = 3'd4
  } reg_idx_t;

endpackage

// ----- rtl/kvf2_in_if.sv -----
// ---------------------------------------------------------------------------
// kvf2_in_if
// Input channel: measured velocities, accelerations and time step.
// ---------------------------------------------------------------------------
interface kvf2_in_if import kvf2_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] meas_vx;
  logic signed [VALUE_WIDTH-1:0] meas_vy;
  logic signed [VALUE_WIDTH-1:0] accel_x;
  logic signed [VALUE_WIDTH-1:0] accel_y;
  logic        [TS_BITS-1:0]     time_step;

  modport source (
    output valid, meas_vx, meas_vy, accel_x, accel_y, time_step,
    input  ready
  );

  modport sink (
    input  valid, meas_vx, meas_vy, accel_x, accel_y, time_step,
    output ready
  );

endinterface

// ----- rtl/kvf2_out_if.sv -----
// ---------------------------------------------------------------------------
// kvf2_out_if
// Output channel: filtered velocity estimates.
// ---------------------------------------------------------------------------
interface kvf2_out_if import kvf2_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] est_vx;
  logic signed [VALUE_WIDTH-1:0] est_vy;

  modport source (
    output valid, est_vx, est_vy,
    input  ready
  );

  modport sink (
    input  valid, est_vx, est_vy,
    output ready
  );

endinterface

// ----- rtl/kvf2_axis.sv -----
// ---------------------------------------------------------------------------
// kvf2_axis
// One scalar Kalman axis: predict, gain by restoring division, update.
// The predict, divide and update steps share a single adder under a small sequencer.
// ---------------------------------------------------------------------------
module kvf2_axis import kvf2_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   reload,
  input  logic [VALUE_WIDTH-1:0] z,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [TS_BITS-1:0]     dt,
  input  logic [VALUE_WIDTH-1:0] q_noise,
  input  logic [VALUE_WIDTH-1:0] r_noise,
  input  logic [VALUE_WIDTH-1:0] init_vel,
  input  logic [VALUE_WIDTH-1:0] init_var,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] vel
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = W + 3;
  localparam int RW = W + 2;
  localparam int MW = (F > TS_BITS) ? F : TS_BITS;
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_AMAG = 13'h0002,
    S_ADT  = 13'h0004,
    S_XP   = 13'h0008,
    S_PP   = 13'h0010,
    S_DEN  = 13'h0020,
    S_DIV  = 13'h0040,
    S_DIFF = 13'h0080,
    S_DMAG = 13'h0100,
    S_MUL1 = 13'h0200,
    S_VEL  = 13'h0400,
    S_MUL2 = 13'h0800,
    S_VAR  = 13'h1000
  } axis_state_t;

  axis_state_t   state;
  logic [W-1:0]  variance;
  logic [W-1:0]  z_q;
  logic [W-1:0]  a_q;
  logic [W-1:0]  xp;
  logic [W-1:0]  pp;
  logic [W:0]    den;
  logic [RW-1:0] rem;
  logic [F:0]    quo;
  logic [W:0]    mcand;
  logic [MW-1:0] mplr;
  logic [W:0]    acc;
  logic [CW-1:0] cnt;
  logic          dneg;

  logic [SW-1:0] opa;
  logic [SW-1:0] opb;
  logic          sub;
  logic [SW-1:0] sum;
  logic [RW-1:0] rcur;
  logic          ge;
  logic [F-1:0]  kinv;

  function automatic logic [SW-1:0] sext_w(input logic [W-1:0] x);
    return {{3{x[W-1]}}, x};
  endfunction

  function automatic logic [W-1:0] sat(input logic [SW-1:0] s);
    logic top_same;
    top_same = (&s[SW-1:W-1]) | ~(|s[SW-1:W-1]);
    if (top_same) begin
      return s[W-1:0];
    end
    return s[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  assign rcur = (cnt == CW'(F)) ? rem : {rem[RW-2:0], 1'b0};
  assign kinv = '0 - quo[F-1:0];
  assign done = (state == S_VAR);

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (state)
      S_AMAG: begin
        opb = sext_w(a_q);
        sub = a_q[W-1];
      end
      S_ADT, S_MUL1, S_MUL2: begin
        opa = SW'(acc);
        opb = mplr[0] ? SW'(mcand) : '0;
      end
      S_XP: begin
        opa = sext_w(vel);
        opb = SW'(acc);
        sub = a_q[W-1];
      end
      S_PP: begin
        opa = SW'(variance);
        opb = SW'(q_noise);
      end
      S_DEN: begin
        opa = SW'(pp);
        opb = SW'(r_noise);
      end
      S_DIV: begin
        opa = SW'(rcur);
        opb = SW'(den);
        sub = 1'b1;
      end
      S_DIFF: begin
        opa = sext_w(z_q);
        opb = sext_w(xp);
        sub = 1'b1;
      end
      S_DMAG: begin
        opb = {{2{mcand[W]}}, mcand};
        sub = dneg;
      end
      S_VEL: begin
        opa = sext_w(xp);
        opb = SW'(acc);
        sub = dneg;
      end
      default: ;
    endcase
  end

  assign sum = opa + (sub ? ~opb : opb) + SW'(sub);
  assign ge  = ~sum[SW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      if (reload) begin
        vel      <= init_vel;
        variance <= init_var;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            z_q   <= z;
            a_q   <= a;
            mplr  <= MW'(dt);
            state <= S_AMAG;
          end
        end
        S_AMAG: begin
          mcand <= sum[W:0];
          acc   <= '0;
          cnt   <= CW'(TS_BITS - 1);
          state <= S_ADT;
        end
        S_ADT: begin
          acc  <= sum[W+1:1];
          mplr <= mplr >> 1;
          if (cnt == '0) begin
            state <= S_XP;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_XP: begin
          xp    <= sat(sum);
          state <= S_PP;
        end
        S_PP: begin
          pp    <= sum[W] ? '1 : sum[W-1:0];
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= sum[W:0];
          rem   <= RW'(pp);
          quo   <= '0;
          cnt   <= CW'(F);
          state <= (sum[W:0] == '0) ? S_DIFF : S_DIV;
        end
        S_DIV: begin
          rem <= ge ? sum[RW-1:0] : rcur;
          quo <= {quo[F-1:0], ge};
          if (cnt == '0) begin
            state <= S_DIFF;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIFF: begin
          mcand <= sum[W:0];
          dneg  <= sum[SW-1];
          state <= S_DMAG;
        end
        S_DMAG: begin
          mcand <= sum[W:0];
          mplr  <= MW'(quo[F-1:0]);
          cnt   <= CW'(F - 1);
          if (quo[F]) begin
            acc   <= sum[W:0];
            state <= S_VEL;
          end else begin
            acc   <= '0;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          acc  <= sum[W+1:1];
          mplr <= mplr >> 1;
          if (cnt == '0) begin
            state <= S_VEL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_VEL: begin
          vel   <= sat(sum);
          mcand <= (W+1)'(pp);
          mplr  <= MW'(kinv);
          cnt   <= CW'(F - 1);
          if (quo == '0) begin
            acc   <= (W+1)'(pp);
            state <= S_VAR;
          end else begin
            acc   <= '0;
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          acc  <= sum[W+1:1];
          mplr <= mplr >> 1;
          if (cnt == '0) begin
            state <= S_VAR;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_VAR: begin
          variance <= acc[W-1:0];
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/kalman_velocity_fusion_2axis_core.sv -----
// ---------------------------------------------------------------------------
// kalman_velocity_fusion_2axis_core
// Two-axis scalar Kalman velocity fusion with APB configuration.
// ---------------------------------------------------------------------------
// Each input transaction yields one output transaction. Both axes run side
// by side, each on its own adder: a 16-step shift-add multiply for a*dt, a
// FRAC_BITS+1 step restoring division for the gain, and two FRAC_BITS-step
// multiplies for the update, one of which is skipped when the gain comes out
// as zero or one. One transaction is in flight at a time; a finished result
// waits in the output register while the next input is taken. Any write to
// a defined register reloads both velocity estimates and variances, and the
// input is held off while that reload is pending, after the write and after
// reset.
// ---------------------------------------------------------------------------
module kalman_velocity_fusion_2axis_core import kvf2_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int STRIDE_LG  = (VALUE_WIDTH > 32) ? 3 : 2,
  localparam int PADDR_W    = STRIDE_LG + 3,
  localparam int PDATA_W    = (VALUE_WIDTH > 32) ? 64 : 32
) (
  input  logic               clk,
  input  logic               rst,
  kvf2_in_if.sink            in_ch,
  kvf2_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int W = VALUE_WIDTH;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } top_state_t;

  top_state_t state;
  reg_idx_t   idx;
  logic       cfg_wr;
  logic       reload_pend;
  logic       in_acc;
  logic       done_x;
  logic       done_y;
  logic       done_x_q;
  logic       done_y_q;
  logic       all_done;
  logic       out_free;
  logic       out_load;
  logic       out_valid;
  logic [W-1:0] out_vx;
  logic [W-1:0] out_vy;
  logic [W-1:0] vel_x;
  logic [W-1:0] vel_y;

  logic [W-1:0] process_noise;
  logic [W-1:0] measurement_noise;
  logic [W-1:0] initial_variance;
  logic [W-1:0] initial_vx;
  logic [W-1:0] initial_vy;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:STRIDE_LG]);
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (idx)
      REG_PROCESS_NOISE:    prdata = PDATA_W'(process_noise);
      REG_MEAS_NOISE:       prdata = PDATA_W'(measurement_noise);
      REG_INITIAL_VARIANCE: prdata = PDATA_W'(initial_variance);
      REG_INITIAL_VX:       prdata = PDATA_W'(initial_vx);
      REG_INITIAL_VY:       prdata = PDATA_W'(initial_vy);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= W'(PROCESS_NOISE_RST);
      measurement_noise <= W'(MEAS_NOISE_RST);
      initial_variance  <= W'(INITIAL_VARIANCE_RST);
      initial_vx        <= W'(INITIAL_VX_RST);
      initial_vy        <= W'(INITIAL_VY_RST);
      reload_pend       <= 1'b1;
    end else begin
      reload_pend <= 1'b0;
      if (cfg_wr) begin
        case (idx)
          REG_PROCESS_NOISE: begin
            process_noise <= pwdata[W-1:0];
            reload_pend   <= 1'b1;
          end
          REG_MEAS_NOISE: begin
            measurement_noise <= pwdata[W-1:0];
            reload_pend       <= 1'b1;
          end
          REG_INITIAL_VARIANCE: begin
            initial_variance <= pwdata[W-1:0];
            reload_pend      <= 1'b1;
          end
          REG_INITIAL_VX: begin
            initial_vx  <= pwdata[W-1:0];
            reload_pend <= 1'b1;
          end
          REG_INITIAL_VY: begin
            initial_vy  <= pwdata[W-1:0];
            reload_pend <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign in_ch.ready = (state == T_IDLE) && !reload_pend;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign all_done    = (done_x_q | done_x) & (done_y_q | done_y);
  assign out_free    = !out_valid || out_ch.ready;
  assign out_load    = out_free && (((state == T_BUSY) && all_done) || (state == T_HOLD));

  kvf2_axis #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_axis_x (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .reload   (reload_pend),
    .z        (in_ch.meas_vx),
    .a        (in_ch.accel_x),
    .dt       (in_ch.time_step),
    .q_noise  (process_noise),
    .r_noise  (measurement_noise),
    .init_vel (initial_vx),
    .init_var (initial_variance),
    .done     (done_x),
    .vel      (vel_x)
  );

  kvf2_axis #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_axis_y (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .reload   (reload_pend),
    .z        (in_ch.meas_vy),
    .a        (in_ch.accel_y),
    .dt       (in_ch.time_step),
    .q_noise  (process_noise),
    .r_noise  (measurement_noise),
    .init_vel (initial_vy),
    .init_var (initial_variance),
    .done     (done_y),
    .vel      (vel_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      done_x_q  <= 1'b0;
      done_y_q  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_acc) begin
            done_x_q <= 1'b0;
            done_y_q <= 1'b0;
            state    <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (done_x) begin
            done_x_q <= 1'b1;
          end
          if (done_y) begin
            done_y_q <= 1'b1;
          end
          if (all_done) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_vx    <= vel_x;
              out_vy    <= vel_y;
              state     <= T_IDLE;
            end else begin
              state <= T_HOLD;
            end
          end
        end
        T_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_vx    <= vel_x;
            out_vy    <= vel_y;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.est_vx = out_vx;
  assign out_ch.est_vy = out_vy;

endmodule

// ----- rtl/kvf2_checker.sv -----
// ---------------------------------------------------------------------------
// kvf2_checker
// Port-level checks of the two-axis velocity fusion core, bound to the top.
// ---------------------------------------------------------------------------
`include "kalman_velocity_fusion_2axis_core_defines.svh"

module kvf2_checker import kvf2_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] est_vx,
  input logic [VALUE_WIDTH-1:0] est_vy
);

  `KVF2_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input ready right after a transaction")
  `KVF2_ASSERT_NOW(a_no_instant_result, clk, rst, $rose(out_valid), !$past(in_valid && in_ready), "result raised right after input")
  `KVF2_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output valid dropped while stalled")
  `KVF2_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(est_vx) && $stable(est_vy), "output changed while stalled")

endmodule

bind kalman_velocity_fusion_2axis_core kvf2_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_kvf2_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .est_vx    (out_ch.est_vx),
  .est_vy    (out_ch.est_vy)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-axis Kalman velocity fusion core testbench
// Feeds measured velocities, accelerations and time steps through the input
// channel and checks every filtered velocity pair against a fixed-point
// predictor kept in step with the register settings. The directed part
// covers field extremes, saturated prediction and variance, zero and unit
// gain and writes to unmapped registers. The random part runs several
// register settings, with bursty idling on both channels in all but the last.
// ---------------------------------------------------------------------------
module testbench;
  import kvf2_pkg::*;

  localparam int     VW           = VALUE_WIDTH_DEF;
  localparam int     FB           = FRAC_BITS_DEF;
  localparam int     ADDR_W       = 5;
  localparam int     UNMAPPED_REG = 6;
  localparam int     QUIET_LIMIT  = 4000;
  localparam int     HOLD_CYCLES  = 600;
  localparam int     TAIL_CYCLES  = 200;
  localparam int     RAND_PHASES  = 6;
  localparam int     PHASE_ITEMS  = 122;
  localparam longint ONE          = longint'(1) << FB;
  localparam longint U_MAX        = 64'h0000_0000_FFFF_FFFF;
  localparam longint S_MAX        = 64'h0000_0000_7FFF_FFFF;
  localparam longint S_MIN        = -S_MAX - 1;

  typedef struct packed {
    logic signed [VW-1:0]      meas_vx;
    logic signed [VW-1:0]      meas_vy;
    logic signed [VW-1:0]      accel_x;
    logic signed [VW-1:0]      accel_y;
    logic        [TS_BITS-1:0] time_step;
  } fusion_in_t;

  typedef struct packed {
    logic signed [VW-1:0] est_vx;
    logic signed [VW-1:0] est_vy;
  } fusion_est_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  kvf2_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  kvf2_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  kalman_velocity_fusion_2axis_core u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fusion_in_t  pending_meas_q [$];
  fusion_est_t expected_est_q [$];
  fusion_in_t  next_meas;
  fusion_in_t  seen_meas;
  fusion_est_t got_est;
  fusion_est_t want_est;

  logic        [31:0]   cfg_val [0:4];
  logic signed [VW-1:0] vel_est [0:1];
  logic        [VW-1:0] var_est [0:1];
  int                   track_v [0:1];

  int   n_fed;
  int   n_checked;
  int   n_errors;
  int   n_settings;
  int   feed_gap;
  int   drain_gap;
  int   quiet_cycles;
  logic bursts_on;
  logic result_hold;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  function automatic longint sat_signed(input longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic longint frac_mul(input longint m, input longint k);
    if (k >= ONE) return m;
    return (m >>> FB) * k + (((m & (ONE - 1)) * k) >>> FB);
  endfunction

  function automatic void reload_estimates();
    vel_est[0] = cfg_val[REG_INITIAL_VX];
    vel_est[1] = cfg_val[REG_INITIAL_VY];
    var_est[0] = cfg_val[REG_INITIAL_VARIANCE];
    var_est[1] = cfg_val[REG_INITIAL_VARIANCE];
  endfunction

  function automatic logic signed [VW-1:0] kalman_axis(input int ax,
                                                       input logic signed [VW-1:0] z,
                                                       input logic signed [VW-1:0] a,
                                                       input logic [TS_BITS-1:0] dt);
    longint z_l, a_l, dt_l, v_l, pv_l, q_l, r_l;
    longint adt, xp, pp, den, quo, rem, gain, diff, mag, corr;
    int     i;
    z_l  = z;
    a_l  = a;
    dt_l = dt;
    v_l  = vel_est[ax];
    pv_l = var_est[ax];
    q_l  = cfg_val[REG_PROCESS_NOISE];
    r_l  = cfg_val[REG_MEAS_NOISE];
    adt  = ((a_l < 0 ? -a_l : a_l) * dt_l) >>> TS_BITS;
    xp   = sat_signed(v_l + (a_l < 0 ? -adt : adt));
    pp   = pv_l + q_l;
    if (pp > U_MAX) pp = U_MAX;
    den  = pp + r_l;
    gain = 0;
    if (den != 0) begin
      quo = 0;
      rem = pp;
      if (rem >= den) begin
        quo = 1;
        rem = rem - den;
      end
      for (i = 0; i < FB; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          quo = quo | 1;
          rem = rem - den;
        end
      end
      gain = (quo > ONE) ? ONE : quo;
    end
    diff = z_l - xp;
    mag  = (diff < 0) ? -diff : diff;
    corr = frac_mul(mag, gain);
    vel_est[ax] = sat_signed(diff < 0 ? xp - corr : xp + corr);
    var_est[ax] = frac_mul(pp, ONE - gain);
    return vel_est[ax];
  endfunction

  function automatic fusion_est_t fuse_step(input fusion_in_t m);
    fusion_est_t r;
    r.est_vx = kalman_axis(0, m.meas_vx, m.accel_x, m.time_step);
    r.est_vy = kalman_axis(1, m.meas_vy, m.accel_y, m.time_step);
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  function automatic logic [TS_BITS-1:0] rand_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  // setup then access phase; pready is sampled at the access edge
  task automatic cfg_write(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= REG_INITIAL_VY) begin
      cfg_val[idx] = val;
      reload_estimates();
    end
    @(posedge clk);
  endtask

  task automatic add_meas(input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] ax, input logic [31:0] ay,
                          input logic [TS_BITS-1:0] dt);
    fusion_in_t m;
    m.meas_vx   = vx;
    m.meas_vy   = vy;
    m.accel_x   = ax;
    m.accel_y   = ay;
    m.time_step = dt;
    pending_meas_q.push_back(m);
  endtask

  // mostly a drifting trajectory with small noise, the rest arbitrary values
  task automatic add_random_meas();
    logic [31:0]        z [0:1];
    logic [31:0]        a [0:1];
    logic [TS_BITS-1:0] dt;
    int                 k;
    dt = rand_dt();
    for (k = 0; k < 2; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        a[k] = $urandom_range(0, 1 << 19) - (1 << 18);
        track_v[k] = track_v[k] + int'((longint'(int'(a[k])) * longint'(dt)) >>> TS_BITS);
        track_v[k] = track_v[k] % (1 << 24);
        z[k] = track_v[k] + int'($urandom_range(0, 1 << 15)) - (1 << 14);
      end else begin
        a[k] = rand_value();
        z[k] = rand_value();
      end
    end
    add_meas(z[0], z[1], a[0], a[1], dt);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_meas_q.size() != 0 || in_ch.valid || expected_est_q.size() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (feed_gap > 0) begin
        feed_gap = feed_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_meas_q.size() != 0) begin
        next_meas = pending_meas_q.pop_front();
        in_ch.meas_vx   <= next_meas.meas_vx;
        in_ch.meas_vy   <= next_meas.meas_vy;
        in_ch.accel_x   <= next_meas.accel_x;
        in_ch.accel_y   <= next_meas.accel_y;
        in_ch.time_step <= next_meas.time_step;
        in_ch.valid     <= 1'b1;
        if (bursts_on && $urandom_range(0, 5) == 0) feed_gap = $urandom_range(1, 14);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (result_hold) begin
      out_ch.ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap = drain_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (bursts_on && $urandom_range(0, 6) == 0) drain_gap = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      seen_meas.meas_vx   = in_ch.meas_vx;
      seen_meas.meas_vy   = in_ch.meas_vy;
      seen_meas.accel_x   = in_ch.accel_x;
      seen_meas.accel_y   = in_ch.accel_y;
      seen_meas.time_step = in_ch.time_step;
      expected_est_q.push_back(fuse_step(seen_meas));
      n_fed++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got_est.est_vx = out_ch.est_vx;
      got_est.est_vy = out_ch.est_vy;
      if (expected_est_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction pending: vx %h vy %h",
                                  n_checked, got_est.est_vx, got_est.est_vy));
      end else begin
        want_est = expected_est_q.pop_front();
        if (got_est.est_vx !== want_est.est_vx)
          report_mismatch($sformatf("result %0d est_vx got %h expected %h",
                                    n_checked, got_est.est_vx, want_est.est_vx));
        if (got_est.est_vy !== want_est.est_vy)
          report_mismatch($sformatf("result %0d est_vy got %h expected %h",
                                    n_checked, got_est.est_vy, want_est.est_vy));
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("kalman_velocity_fusion_2axis_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the result side long enough for the input to back up
  initial begin
    result_hold = 1'b0;
    wait (n_fed >= 300);
    @(posedge clk);
    result_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    result_hold <= 1'b0;
  end

  initial begin
    int p;
    int n;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    n_settings      = 1;
    bursts_on       = 1'b1;
    track_v[0]      = 0;
    track_v[1]      = 0;
    cfg_val[REG_PROCESS_NOISE]    = PROCESS_NOISE_RST[31:0];
    cfg_val[REG_MEAS_NOISE]       = MEAS_NOISE_RST[31:0];
    cfg_val[REG_INITIAL_VARIANCE] = INITIAL_VARIANCE_RST[31:0];
    cfg_val[REG_INITIAL_VX]       = INITIAL_VX_RST[31:0];
    cfg_val[REG_INITIAL_VY]       = INITIAL_VY_RST[31:0];
    reload_estimates();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    add_meas(32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    add_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h0);
    add_meas(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 16'h0);
    add_meas(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    add_meas(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    add_meas(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 16'h1);
    add_meas(32'h0, 32'h0, 32'hFFFF_FFFD, 32'h3, 16'h8000);
    add_meas(32'h1234_5678, 32'hEDCB_A987, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5A5A);
    wait_drained();

    // saturated prediction and saturated variance
    n_settings++;
    cfg_write(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    cfg_write(REG_INITIAL_VARIANCE, 32'hFFFF_FFFF);
    cfg_write(REG_INITIAL_VX, 32'h7FFF_FFFF);
    cfg_write(REG_INITIAL_VY, 32'h8000_0000);
    @(negedge clk);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    add_meas(32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    wait_drained();

    // zero denominator
    n_settings++;
    cfg_write(REG_PROCESS_NOISE, 32'h0);
    cfg_write(REG_MEAS_NOISE, 32'h0);
    cfg_write(REG_INITIAL_VARIANCE, 32'h0);
    cfg_write(REG_INITIAL_VX, 32'h0001_0000);
    cfg_write(REG_INITIAL_VY, 32'hFFFF_0000);
    @(negedge clk);
    add_meas(32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 32'hFFFE_0000, 16'h4000);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'hFFFF);
    wait_drained();

    // unit gain, then an unmapped write that must leave the estimates alone
    n_settings++;
    cfg_write(REG_INITIAL_VARIANCE, 32'h0000_8000);
    @(negedge clk);
    add_meas(32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0, 16'h0);
    add_meas(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 16'h1000);
    wait_drained();
    cfg_write(UNMAPPED_REG, 32'hDEAD_BEEF);
    @(negedge clk);
    add_meas(32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
    add_meas(32'h0000_1000, 32'hFFFF_F000, 32'h0, 32'h0, 16'h0);
    wait_drained();

    // gain near one half from large variance and measurement noise
    n_settings++;
    cfg_write(REG_MEAS_NOISE, 32'hFFFF_FFFF);
    cfg_write(REG_INITIAL_VARIANCE, 32'hFFFF_FFFF);
    @(negedge clk);
    add_meas(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 16'h0);
    add_meas(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    wait_drained();

    for (p = 0; p < RAND_PHASES; p++) begin
      n_settings++;
      if (p == RAND_PHASES - 1) begin
        bursts_on = 1'b0;
        cfg_write(REG_PROCESS_NOISE, PROCESS_NOISE_RST[31:0]);
        cfg_write(REG_MEAS_NOISE, MEAS_NOISE_RST[31:0]);
        cfg_write(REG_INITIAL_VARIANCE, INITIAL_VARIANCE_RST[31:0]);
        cfg_write(REG_INITIAL_VX, INITIAL_VX_RST[31:0]);
        cfg_write(REG_INITIAL_VY, INITIAL_VY_RST[31:0]);
      end else begin
        if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_PROCESS_NOISE, rand_noise());
        if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_MEAS_NOISE, rand_noise());
        if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_INITIAL_VARIANCE, rand_noise());
        if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_INITIAL_VX, rand_value());
        if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_INITIAL_VY, rand_value());
        if ($urandom_range(0, 3) == 0) cfg_write(UNMAPPED_REG, $urandom);
      end
      track_v[0] = int'(vel_est[0]) % (1 << 24);
      track_v[1] = int'(vel_est[1]) % (1 << 24);
      @(negedge clk);
      for (n = 0; n < PHASE_ITEMS; n++) add_random_meas();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_est_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_est_q.size()));
    $display("Run covered %0d input transactions across %0d register settings,",
             n_fed, n_settings);
    $display("with %0d velocity pairs checked and %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("kalman_velocity_fusion_2axis_core test passed");
    end else begin
      $display("kalman_velocity_fusion_2axis_core test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/kvf2_pkg.sv
rtl/kvf2_in_if.sv
rtl/kvf2_out_if.sv
rtl/kvf2_axis.sv
rtl/kalman_velocity_fusion_2axis_core.sv
rtl/kvf2_checker.sv
tb/testbench.sv
